/* src/ddph_pkg.sv */
// Shared types and constants for the detector/depth pixel histogram.
// Used by ddph_ctrl, ddph_datapath and detector_depth_pixel_histogram_core.
`default_nettype none

package ddph_pkg;

  // Default sizes of the histogram store
  localparam int DEF_NUM_DETECTORS  = 192;
  localparam int DEF_MAX_DEPTH_BINS = 8;
  localparam int DEF_COUNT_WIDTH    = 16;

  // Fixed field widths
  localparam int BYTE_W     = 8;
  localparam int RD_BIN_W   = 3;
  localparam int CFG_W      = 2;
  localparam int SHIFT_W    = 4;

  // Item function codes
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } ddph_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;   // write zero at the sweep address
    logic accept;  // capture item, issue store read
    logic exec;    // write back, present result
  } ddph_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;  // sweep is at the last store entry
  } ddph_status_t;

endpackage

`default_nettype wire

/* src/ddph_ctrl.sv */
// Controller state machine for the pixel histogram: clearing sweep, idle, execute.
// Depends on ddph_pkg for the state and command types.
`default_nettype none

module ddph_ctrl
  import ddph_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire ddph_status_t status,
  output ddph_cmd_t         cmd,
  output logic              busy
);

  ddph_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
      end
      ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/ddph_datapath.sv */
// Datapath for the pixel histogram: config register, address decode,
// count store with read-modify-write, clearing sweep and result registers.
// Depends on ddph_pkg for widths and command/status types.
`default_nettype none

module ddph_datapath
  import ddph_pkg::*;
#(
  parameter int NUM_DETECTORS  = DEF_NUM_DETECTORS,
  parameter int MAX_DEPTH_BINS = DEF_MAX_DEPTH_BINS,
  parameter int COUNT_WIDTH    = DEF_COUNT_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire ddph_cmd_t              cmd,
  output ddph_status_t                status,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_W-1:0]       cfg_wr_data,
  input  wire logic                   func,
  input  wire logic [BYTE_W-1:0]      red_byte,
  input  wire logic [BYTE_W-1:0]      blue_byte,
  input  wire logic [BYTE_W-1:0]      read_detector,
  input  wire logic [RD_BIN_W-1:0]    read_bin,
  output logic                        count_valid,
  output logic [COUNT_WIDTH-1:0]      count,
  output logic [BYTE_W-1:0]           count_detector,
  output logic [RD_BIN_W-1:0]         count_bin
);

  localparam int STORE_DEPTH = NUM_DETECTORS * MAX_DEPTH_BINS;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [ADDR_W-1:0]      LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

  // Depth bin configuration register
  logic [CFG_W-1:0] depth_bins_log2;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_bins_log2 <= '0;
    end else if (cfg_wr_en) begin
      depth_bins_log2 <= cfg_wr_data;
    end
  end

  // Decode the incoming item into a store address and an in-range flag
  logic [SHIFT_W-1:0] shamt;
  logic [BYTE_W-1:0]  pix_bin;
  logic [BYTE_W-1:0]  pix_det;
  logic [BYTE_W-1:0]  det_sel;
  logic [BYTE_W-1:0]  bin_sel;
  logic               pix_ok;
  logic               rd_ok;
  logic               item_ok;
  logic [ADDR_W-1:0]  item_addr;

  always_comb begin
    shamt    = SHIFT_W'(BYTE_W) - SHIFT_W'(depth_bins_log2);
    pix_bin  = blue_byte >> shamt;
    pix_det  = red_byte - BYTE_W'(1);
    pix_ok   = (red_byte != '0) && (32'(red_byte) <= NUM_DETECTORS)
               && (32'(pix_bin) < MAX_DEPTH_BINS);
    rd_ok    = (32'(read_detector) < NUM_DETECTORS) && (32'(read_bin) < MAX_DEPTH_BINS);
    det_sel  = (func == FUNC_READ) ? read_detector : pix_det;
    bin_sel  = (func == FUNC_READ) ? BYTE_W'(read_bin) : pix_bin;
    item_ok  = (func == FUNC_READ) ? rd_ok : pix_ok;
    item_addr = ADDR_W'(32'(det_sel) * MAX_DEPTH_BINS + 32'(bin_sel));
  end

  // Captured item
  logic                func_q;
  logic                ok_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [BYTE_W-1:0]   det_q;
  logic [RD_BIN_W-1:0] bin_q;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_q <= func;
      ok_q   <= item_ok;
      addr_q <= item_addr;
      det_q  <= read_detector;
      bin_q  <= read_bin;
    end
  end

  // Clearing sweep address
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  assign status.clear_last = (clr_addr == LAST_ADDR);

  // Write-back value: saturating increment for pixels, zero for reads
  logic [COUNT_WIDTH-1:0] rd_data;
  logic [COUNT_WIDTH-1:0] upd_data;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic [ADDR_W-1:0]      wr_addr;
  logic                   wr_en;

  always_comb begin
    upd_data = (rd_data == COUNT_MAX) ? rd_data : rd_data + COUNT_WIDTH'(1);
    wr_data  = (cmd.clear || func_q == FUNC_READ) ? '0 : upd_data;
    wr_addr  = cmd.clear ? clr_addr : addr_q;
    wr_en    = cmd.clear || (cmd.exec && ok_q);
  end

  // Count store, one write and one registered read port
  logic [COUNT_WIDTH-1:0] store [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_data <= store[item_addr];
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count_valid <= 1'b0;
    end else begin
      count_valid <= cmd.exec && (func_q == FUNC_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      count          <= ok_q ? rd_data : '0;
      count_detector <= det_q;
      count_bin      <= bin_q;
    end
  end

endmodule

`default_nettype wire

/* src/detector_depth_pixel_histogram_core.sv */
// Detector/depth pixel histogram, top level: controller plus datapath.
// Each item is accepted in idle, then handled in the execute state; busy is
// high during execute. A read result appears on count_* for one cycle with
// count_valid, registered from the execute state; it cannot be stalled.
// The registered store read splits the read-modify-write into accept and execute.
// After reset a clearing sweep over all NUM_DETECTORS * MAX_DEPTH_BINS entries
// (1536 by default) runs with busy high; config writes are taken throughout.
`default_nettype none

module detector_depth_pixel_histogram_core
  import ddph_pkg::*;
#(
  parameter int NUM_DETECTORS  = DEF_NUM_DETECTORS,
  parameter int MAX_DEPTH_BINS = DEF_MAX_DEPTH_BINS,
  parameter int COUNT_WIDTH    = DEF_COUNT_WIDTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                cfg_wr_en,
  input  wire logic [CFG_W-1:0]    cfg_wr_data,
  input  wire logic                func,
  input  wire logic [BYTE_W-1:0]   red_byte,
  input  wire logic [BYTE_W-1:0]   blue_byte,
  input  wire logic [BYTE_W-1:0]   read_detector,
  input  wire logic [RD_BIN_W-1:0] read_bin,
  output logic                     count_valid,
  output logic [COUNT_WIDTH-1:0]   count,
  output logic [BYTE_W-1:0]        count_detector,
  output logic [RD_BIN_W-1:0]      count_bin
);

  ddph_cmd_t    cmd;
  ddph_status_t status;

  // Sequencer
  ddph_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Store and arithmetic
  ddph_datapath #(
    .NUM_DETECTORS  (NUM_DETECTORS),
    .MAX_DEPTH_BINS (MAX_DEPTH_BINS),
    .COUNT_WIDTH    (COUNT_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .func           (func),
    .red_byte       (red_byte),
    .blue_byte      (blue_byte),
    .read_detector  (read_detector),
    .read_bin       (read_bin),
    .count_valid    (count_valid),
    .count          (count),
    .count_detector (count_detector),
    .count_bin      (count_bin)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_detector_depth_pixel_histogram_core.sv */
// Self-checking testbench for detector_depth_pixel_histogram_core.
// Needs ddph_pkg and the core RTL. A built-in histogram predictor supplies the
// expected read-back counts, which are checked one by one as each result arrives.
module tb_detector_depth_pixel_histogram_core;
  import ddph_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_DET     = DEF_NUM_DETECTORS;
  localparam int NUM_BINS    = DEF_MAX_DEPTH_BINS;
  localparam int CNT_W       = DEF_COUNT_WIDTH;
  localparam int STORE_SIZE  = NUM_DET * NUM_BINS;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_PRINTED = 20;
  localparam int REPEAT_HITS = 40;
  localparam logic [CNT_W-1:0] COUNT_SAT = '1;

  typedef struct {
    logic                fn;
    logic [BYTE_W-1:0]   red;
    logic [BYTE_W-1:0]   blue;
    logic [BYTE_W-1:0]   rdet;
    logic [RD_BIN_W-1:0] rbin;
  } hist_item_t;

  typedef struct {
    logic [CNT_W-1:0]    cnt;
    logic [BYTE_W-1:0]   det;
    logic [RD_BIN_W-1:0] bin;
  } count_result_t;

  // DUT-facing signals; the driven inputs are known from time zero
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic                cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]    cfg_wr_data = '0;
  logic                func = FUNC_PIXEL;
  logic [BYTE_W-1:0]   red_byte = '0;
  logic [BYTE_W-1:0]   blue_byte = '0;
  logic [BYTE_W-1:0]   read_detector = '0;
  logic [RD_BIN_W-1:0] read_bin = '0;
  logic                count_valid;
  logic [CNT_W-1:0]    count;
  logic [BYTE_W-1:0]   count_detector;
  logic [RD_BIN_W-1:0] count_bin;

  // Predictor state and bookkeeping
  logic [CNT_W-1:0]    count_store [STORE_SIZE];
  logic [CFG_W-1:0]    depth_log2;
  count_result_t       pending_counts [$];
  int                  error_count = 0;
  int                  items_sent = 0;
  int                  reads_checked = 0;
  int                  cycle_count = 0;

  detector_depth_pixel_histogram_core uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .func           (func),
    .red_byte       (red_byte),
    .blue_byte      (blue_byte),
    .read_detector  (read_detector),
    .read_bin       (read_bin),
    .count_valid    (count_valid),
    .count          (count),
    .count_detector (count_detector),
    .count_bin      (count_bin)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d counts still due", cycle_count,
               pending_counts.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTED)
      $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Histogram predictor: updates the store copy, queues a result per read
  task automatic predict_histogram(input hist_item_t it);
    int det_idx;
    int bin_idx;
    int addr;
    count_result_t res;
    if (it.fn == FUNC_PIXEL) begin
      // background and unknown detectors leave the store alone
      if (it.red != 0 && int'(it.red) <= NUM_DET) begin
        det_idx = int'(it.red) - 1;
        bin_idx = int'(it.blue) >> (BYTE_W - int'(depth_log2));
        if (bin_idx < NUM_BINS) begin
          addr = det_idx * NUM_BINS + bin_idx;
          if (count_store[addr] != COUNT_SAT)
            count_store[addr] = count_store[addr] + 1'b1;
        end
      end
    end else begin
      res.cnt = '0;
      res.det = it.rdet;
      res.bin = it.rbin;
      // out-of-range reads echo the address, return zero, clear nothing
      if (int'(it.rdet) < NUM_DET && int'(it.rbin) < NUM_BINS) begin
        addr = int'(it.rdet) * NUM_BINS + int'(it.rbin);
        res.cnt = count_store[addr];
        count_store[addr] = '0;
      end
      pending_counts.push_back(res);
    end
  endtask

  // Result checker: results cannot be stalled, so take every strobe
  always @(posedge clk) begin
    count_result_t want;
    if (!rst && count_valid) begin
      if (pending_counts.size() == 0) begin
        report_mismatch($sformatf("unexpected result det %0d bin %0d count %0d",
                                  count_detector, count_bin, count));
      end else begin
        want = pending_counts.pop_front();
        reads_checked++;
        if (count !== want.cnt)
          report_mismatch($sformatf("count det %0d bin %0d: got %0d want %0d",
                                    want.det, want.bin, count, want.cnt));
        if (count_detector !== want.det)
          report_mismatch($sformatf("count_detector: got %0d want %0d",
                                    count_detector, want.det));
        if (count_bin !== want.bin)
          report_mismatch($sformatf("count_bin: got %0d want %0d", count_bin, want.bin));
      end
    end
  end

  // Send one item, predict it at the accepting edge, then maybe idle
  task automatic send_item(input hist_item_t it, input int idle_pct);
    start         <= 1'b1;
    func          <= it.fn;
    red_byte      <= it.red;
    blue_byte     <= it.blue;
    read_detector <= it.rdet;
    read_bin      <= it.rbin;
    do @(posedge clk); while (busy);
    predict_histogram(it);
    items_sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Stop sending, let all results land and the last pixel write back
  task automatic wait_drain();
    start <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_depth_cfg(input logic [CFG_W-1:0] value);
    wait_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    depth_log2 = value;
  endtask

  function automatic hist_item_t pixel_item(input int red, input int blue);
    hist_item_t it;
    it.fn   = FUNC_PIXEL;
    it.red  = red[BYTE_W-1:0];
    it.blue = blue[BYTE_W-1:0];
    it.rdet = '0;
    it.rbin = '0;
    return it;
  endfunction

  function automatic hist_item_t read_item(input int det, input int bin);
    hist_item_t it;
    it.fn   = FUNC_READ;
    it.red  = '0;
    it.blue = '0;
    it.rdet = det[BYTE_W-1:0];
    it.rbin = bin[RD_BIN_W-1:0];
    return it;
  endfunction

  // Random item aimed at a small group of hot detectors so reads find counts
  function automatic hist_item_t random_item(input int hot_det, input int used_bins);
    hist_item_t it;
    int sel;
    it.fn   = ($urandom_range(0, 99) < 35) ? FUNC_READ : FUNC_PIXEL;
    it.blue = BYTE_W'($urandom_range(0, 255));
    sel = $urandom_range(0, 99);
    if (sel < 50)      it.red = BYTE_W'(hot_det + $urandom_range(0, 3) + 1);
    else if (sel < 75) it.red = BYTE_W'($urandom_range(1, NUM_DET));
    else if (sel < 87) it.red = '0;
    else               it.red = BYTE_W'($urandom_range(NUM_DET + 1, 255));
    sel = $urandom_range(0, 99);
    if (sel < 60)      it.rdet = BYTE_W'(hot_det + $urandom_range(0, 3));
    else if (sel < 85) it.rdet = BYTE_W'($urandom_range(0, NUM_DET - 1));
    else               it.rdet = BYTE_W'($urandom_range(NUM_DET, 255));
    if ($urandom_range(0, 99) < 70) it.rbin = RD_BIN_W'($urandom_range(0, used_bins - 1));
    else                            it.rbin = RD_BIN_W'($urandom_range(0, NUM_BINS - 1));
    return it;
  endfunction

  task automatic reset_block();
    foreach (count_store[i]) count_store[i] = '0;
    depth_log2 = '0;
    rst <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  endtask

  // Background, detector extremes, unknown detectors, reads in and out of range
  task automatic test_pixel_extremes();
    write_depth_cfg(2'd0);
    send_item(pixel_item(0, 8'h55), 0);
    send_item(pixel_item(1, 0), 0);
    send_item(pixel_item(NUM_DET, 255), 0);
    send_item(pixel_item(NUM_DET + 1, 0), 0);
    send_item(pixel_item(255, 255), 0);
    send_item(read_item(0, 0), 0);
    send_item(read_item(NUM_DET - 1, 0), 0);
    send_item(read_item(0, 0), 0);
    send_item(read_item(NUM_DET, 0), 0);
    send_item(read_item(255, NUM_BINS - 1), 0);
    send_item(read_item(0, NUM_BINS - 1), 0);
  endtask

  // Bin selection at each register setting, plus a bin left over after lowering
  task automatic test_depth_bins();
    write_depth_cfg(2'd3);
    send_item(pixel_item(5, 8'hE0), 0);
    send_item(pixel_item(5, 8'h20), 0);
    send_item(pixel_item(5, 8'h3F), 0);
    write_depth_cfg(2'd0);
    send_item(read_item(4, 7), 0);
    send_item(read_item(4, 1), 0);
    write_depth_cfg(2'd1);
    send_item(pixel_item(9, 8'h80), 0);
    send_item(pixel_item(9, 8'h7F), 0);
    send_item(read_item(8, 1), 0);
    write_depth_cfg(2'd2);
    send_item(pixel_item(9, 8'hC0), 0);
    send_item(read_item(8, 3), 0);
    send_item(read_item(8, 0), 0);
  endtask

  // Same address back to back, then read it and read it again after the clear
  task automatic test_repeat_hits();
    write_depth_cfg(2'd0);
    repeat (REPEAT_HITS) send_item(pixel_item(11, 8'h10), 0);
    send_item(read_item(10, 0), 0);
    send_item(read_item(10, 0), 0);
  endtask

  task automatic test_random_phase(input int n, input int idle_pct,
                                   input logic [CFG_W-1:0] log2v);
    int hot_det;
    write_depth_cfg(log2v);
    hot_det = $urandom_range(0, NUM_DET - 4);
    repeat (n) send_item(random_item(hot_det, 1 << log2v), idle_pct);
  endtask

  initial begin
    int hit_items;
    reset_block();
    test_pixel_extremes();
    test_depth_bins();
    hit_items = items_sent;
    test_repeat_hits();
    hit_items = items_sent - hit_items;
    // idle mixes: none (receiver cannot stall), 65% and 34%, over all four depth settings
    test_random_phase(210, 0,  2'd3);
    test_random_phase(210, 65, 2'd0);
    test_random_phase(210, 0,  2'd2);
    test_random_phase(210, 34, 2'd1);
    test_random_phase(210, 65, 2'd3);
    test_random_phase(210, 34, 2'd2);
    test_random_phase(210, 65, 2'd1);
    test_random_phase(210, 0,  2'd0);
    wait_drain();
    repeat (8) @(posedge clk);
    $display("covered: %0d items (%0d in the repeated-address run), %0d counts read back",
             items_sent, hit_items, reads_checked);
    $display("all four depth settings, background/unknown pixels, out-of-range reads");
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
